// ----- rtl/spq_pkg.sv -----
package spq_pkg;

    // Queue depth and derived widths
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // Stream word widths (padded to whole bytes)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 144;

    // Operation codes
    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_DEQ  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // One stored element
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    // Per-cell control broadcast from the queue controller
    typedef struct packed {
        logic enq;       // insert the broadcast item this cycle
        logic deq;       // shift every cell toward the front
        logic occupied;  // this cell holds a live element
        logic at_tail;   // this cell is the first free slot
    } cell_ctrl_t;

endpackage

// ----- rtl/spq_cell.sv -----
module spq_cell (
    input  logic                aclk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t     item,
    input  logic                prev_greater,
    input  spq_pkg::entry_t     prev_entry,
    input  spq_pkg::entry_t     next_entry,
    output logic                greater,
    output spq_pkg::entry_t     entry_q
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // New item outranks the element held here
    assign greater = ctrl.occupied && (item.prio > entry_reg.prio);

    // Insert: take from the neighbor ahead when it moves back, load the item at the
    // insertion point. Remove: take from the neighbor behind.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.enq) begin
            if (prev_greater) begin
                entry_next = prev_entry;
            end else if (greater || ctrl.at_tail) begin
                entry_next = item;
            end
        end else if (ctrl.deq) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;

endmodule

// ----- rtl/sorted_priority_queue_core.sv -----
// Sorted priority queue, highest priority at the front, ties leave in arrival order.
// Input stream (s_*): one word per command: enqueue, dequeue or peek.
// Result stream (m_*): exactly one word per command with status, removed element,
// front element, occupancy and an empty flag, all as seen after the command.
// Storage is a row of identical cells; each compares the broadcast priority with its
// own element and shifts toward or away from the front in the same cycle, so the
// time a command takes does not depend on where the element lands.
// The result word appears in the cycle after the command is accepted.
// Throughput: one command per cycle while the result side keeps up.
// The result sits in an output register; a new command is taken when that register
// is empty or being drained in the same cycle. While m_tready is low and a result
// waits, s_tready is low and the queue holds.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
// Full enqueue reports overflow; dequeue or peek on an empty queue reports underflow;
// in both cases the contents stay unchanged. Operation code three does nothing.
module sorted_priority_queue_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operation[1:0], item_value[33:2], item_priority[65:34], zero pad
    input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], taken_value[33:2], taken_priority[65:34], front_value[97:66],
    // front_priority[129:98], occupancy[136:130], is_empty[137], zero pad
    output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int CAP   = spq_pkg::CAPACITY;
    localparam int CNT_W = spq_pkg::CNT_W;
    localparam int DW    = spq_pkg::DATA_W;
    localparam int OUT_USED = 2 + 4 * DW + CNT_W + 1;
    localparam int M_TDATA_W_L = spq_pkg::M_TDATA_W;

    logic [1:0]      op;
    spq_pkg::entry_t item;
    logic            in_fire;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                       m_tvalid_reg;
    logic [M_TDATA_W_L-1:0]     m_tdata_reg;
    logic [M_TDATA_W_L-1:0]     m_tdata_next;

    spq_pkg::entry_t cell_entry [CAP];
    logic            cell_greater [CAP];

    logic            is_full;
    logic            is_zero;
    logic            do_enq;
    logic            do_deq;
    logic [1:0]      status;
    spq_pkg::entry_t taken;
    spq_pkg::entry_t front;

    // Unpack the command word
    assign op        = s_tdata[1:0];
    assign item.value = s_tdata[2 +: DW];
    assign item.prio  = s_tdata[2 + DW +: DW];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    assign is_full = (count_reg == CNT_W'(CAP));
    assign is_zero = (count_reg == '0);
    assign do_enq  = in_fire && (op == spq_pkg::OP_ENQ) && !is_full;
    assign do_deq  = in_fire && (op == spq_pkg::OP_DEQ) && !is_zero;

    // Row of storage cells
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        spq_pkg::cell_ctrl_t ctrl;
        logic                prev_greater;
        spq_pkg::entry_t     prev_entry;
        spq_pkg::entry_t     next_entry;

        assign ctrl.enq      = do_enq;
        assign ctrl.deq      = do_deq;
        assign ctrl.occupied = (CNT_W'(i) < count_reg);
        assign ctrl.at_tail  = (CNT_W'(i) == count_reg);

        if (i == 0) begin : g_head
            assign prev_greater = 1'b0;
            assign prev_entry   = item;
        end else begin : g_body
            assign prev_greater = cell_greater[i-1];
            assign prev_entry   = cell_entry[i-1];
        end

        if (i == CAP - 1) begin : g_last
            assign next_entry = cell_entry[i];
        end else begin : g_inner
            assign next_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .item         (item),
            .prev_greater (prev_greater),
            .prev_entry   (prev_entry),
            .next_entry   (next_entry),
            .greater      (cell_greater[i]),
            .entry_q      (cell_entry[i])
        );
    end

    // Build the result for the accepted command
    always_comb begin
        status     = spq_pkg::ST_OK;
        taken      = '0;
        count_next = count_reg;
        front      = is_zero ? '0 : cell_entry[0];
        case (op)
            spq_pkg::OP_ENQ: begin
                if (is_full) begin
                    status = spq_pkg::ST_OVERFLOW;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    if (is_zero || cell_greater[0]) begin
                        front = item;
                    end
                end
            end
            spq_pkg::OP_DEQ: begin
                if (is_zero) begin
                    status = spq_pkg::ST_UNDERFLOW;
                end else begin
                    taken      = cell_entry[0];
                    count_next = count_reg - CNT_W'(1);
                    front      = (count_reg == CNT_W'(1)) ? '0 : cell_entry[1];
                end
            end
            spq_pkg::OP_PEEK: begin
                if (is_zero) begin
                    status = spq_pkg::ST_UNDERFLOW;
                end
            end
            default: begin
                status = spq_pkg::ST_OK;
            end
        endcase
        m_tdata_next = {
            (M_TDATA_W_L - OUT_USED)'(0),
            (count_next == '0),
            count_next,
            front.prio,
            front.value,
            taken.prio,
            taken.value,
            status
        };
    end

    // Hold count and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAP))
        else $error("queue count above capacity");

    a_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && op == spq_pkg::OP_ENQ && is_full)
        |=> (m_tdata_reg[1:0] == spq_pkg::ST_OVERFLOW && count_reg == CNT_W'(CAP)))
        else $error("full enqueue not refused");

    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        do_deq |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("dequeue did not shrink the queue");

    a_sorted_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
        else $error("front cells out of priority order");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[2 + 4*DW + CNT_W]
                          == (m_tdata_reg[2 + 4*DW +: CNT_W] == '0)))
        else $error("empty flag disagrees with occupancy");

endmodule
